// File: hdl/srr_pkg.sv
package srr_pkg;

	// Result item codes
	localparam logic       KIND_DATA    = 1'b0;
	localparam logic       KIND_ACK     = 1'b1;
	localparam logic [1:0] ACK_OK       = 2'd0;
	localparam logic [1:0] ACK_CSUM_ERR = 2'd1;
	localparam logic [1:0] ACK_SEQ_ERR  = 2'd2;
	localparam logic [4:0] ACK_NONE     = 5'h1F;

	// Microprogram addresses
	typedef enum logic [3:0] {
		STEP_IDLE      = 4'd0,
		STEP_CHK_SPACE = 4'd1,
		STEP_CHK_CSUM  = 4'd2,
		STEP_CHK_WIN   = 4'd3,
		STEP_CHK_EXP   = 4'd4,
		STEP_FIRST     = 4'd5,
		STEP_SCAN      = 4'd6,
		STEP_SEND      = 4'd7,
		STEP_ACK_OK    = 4'd8,
		STEP_ACK_CSUM  = 4'd9,
		STEP_ACK_SEQ   = 4'd10,
		STEP_STORE     = 4'd11
	} step_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_JUMP,
		BR_IF
	} br_t;

	typedef enum logic [2:0] {
		COND_DROP,
		COND_BAD_CSUM,
		COND_OUTSIDE,
		COND_NOT_EXP,
		COND_RUN_END
	} cond_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_ITEM_PAY,
		EMIT_HELD_PAY,
		EMIT_ACK_OK,
		EMIT_ACK_CSUM,
		EMIT_ACK_SEQ
	} emit_t;

	// One control word of the microprogram
	typedef struct packed {
		logic  needs_in;
		logic  needs_out;
		br_t   br;
		cond_t cond;
		step_t target;
		emit_t emit;
		logic  ld_item;
		logic  scan_init;
		logic  scan_adv;
		logic  set_base;
		logic  upd_ack;
		logic  store;
	} ctrl_word_t;

	// Sequencer to datapath
	typedef struct packed {
		step_t      step;
		ctrl_word_t uw;
		logic       go;
	} srr_ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic drop;
		logic bad_csum;
		logic outside;
		logic not_exp;
		logic run_end;
	} srr_stat_t;

	// Control store
	function automatic ctrl_word_t ucode(step_t s);
		ctrl_word_t w;
		w = '0;
		case (s)
			STEP_IDLE: begin
				w.needs_in = 1'b1;
				w.ld_item  = 1'b1;
			end
			STEP_CHK_SPACE: begin
				w.br     = BR_IF;
				w.cond   = COND_DROP;
				w.target = STEP_IDLE;
			end
			STEP_CHK_CSUM: begin
				w.br     = BR_IF;
				w.cond   = COND_BAD_CSUM;
				w.target = STEP_ACK_CSUM;
			end
			STEP_CHK_WIN: begin
				w.br     = BR_IF;
				w.cond   = COND_OUTSIDE;
				w.target = STEP_ACK_SEQ;
			end
			STEP_CHK_EXP: begin
				w.br     = BR_IF;
				w.cond   = COND_NOT_EXP;
				w.target = STEP_STORE;
			end
			STEP_FIRST: begin
				w.needs_out = 1'b1;
				w.emit      = EMIT_ITEM_PAY;
				w.scan_init = 1'b1;
			end
			STEP_SCAN: begin
				w.br     = BR_IF;
				w.cond   = COND_RUN_END;
				w.target = STEP_ACK_OK;
			end
			STEP_SEND: begin
				w.needs_out = 1'b1;
				w.emit      = EMIT_HELD_PAY;
				w.scan_adv  = 1'b1;
				w.br        = BR_JUMP;
				w.target    = STEP_SCAN;
			end
			STEP_ACK_OK: begin
				w.needs_out = 1'b1;
				w.emit      = EMIT_ACK_OK;
				w.set_base  = 1'b1;
				w.upd_ack   = 1'b1;
				w.br        = BR_JUMP;
				w.target    = STEP_IDLE;
			end
			STEP_ACK_CSUM: begin
				w.needs_out = 1'b1;
				w.emit      = EMIT_ACK_CSUM;
				w.br        = BR_JUMP;
				w.target    = STEP_IDLE;
			end
			STEP_ACK_SEQ: begin
				w.needs_out = 1'b1;
				w.emit      = EMIT_ACK_SEQ;
				w.upd_ack   = 1'b1;
				w.br        = BR_JUMP;
				w.target    = STEP_IDLE;
			end
			STEP_STORE: begin
				w.needs_out = 1'b1;
				w.emit      = EMIT_ACK_OK;
				w.store     = 1'b1;
				w.upd_ack   = 1'b1;
				w.br        = BR_JUMP;
				w.target    = STEP_IDLE;
			end
			default: begin
				w.br     = BR_JUMP;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: hdl/srr_if.sv
// Arriving packet channel
interface srr_pkt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  seq_num;
	logic        checksum_ok;
	logic [63:0] payload;

	modport source (output valid, seq_num, checksum_ok, payload, input ready);
	modport sink   (input valid, seq_num, checksum_ok, payload, output ready);
endinterface

// Result channel: delivered payloads and acknowledgements
interface srr_res_if;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [63:0]       data_out;
	logic signed [4:0] ack_num;
	logic [1:0]        ack_status;
	logic              last;

	modport source (output valid, kind, data_out, ack_num, ack_status, last, input ready);
	modport sink   (input valid, kind, data_out, ack_num, ack_status, last, output ready);
endinterface

// File: hdl/selective_repeat_receiver_unit.sv
// Each packet passes the space, checksum, window and expected-sequence checks in turn.
// A dropped packet emits nothing; a checksum failure or a duplicate emits one ack; a
// buffered packet is stored and acked; an in-order packet emits its payload, its run of
// held payloads, then an ack. The microprogram steps one control word per cycle unless a
// step waits for a packet or a free result slot; a new packet is taken only when idle.
// Reset: window base 0, held flags cleared, last ack number -1; held RAM not cleared.
module selective_repeat_receiver_unit
	import srr_pkg::*;
#(
	parameter int SEQ_SPACE    = 16,
	parameter int WINDOW       = 8,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	srr_pkt_if.sink   packet,
	srr_res_if.source result
);

	srr_ctrl_t ctrl;
	srr_stat_t stat;

	srr_sequencer u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	srr_datapath #(
		.SEQ_SPACE   (SEQ_SPACE),
		.WINDOW      (WINDOW),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.stat  (stat),
		.packet(packet),
		.result(result)
	);

	// A packet transaction always leads to the sequence-space check
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(packet.valid && packet.ready) |=> (ctrl.step == STEP_CHK_SPACE))
		else $error("packet transaction not followed by the space check");

	// An emitting step always presents a result in the next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.go && ctrl.uw.emit != EMIT_NONE) |=> result.valid)
		else $error("emitted item not presented");

	// A held payload is only sent from a slot that is held and within the run limit
	a_send_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step == STEP_SEND) |-> !stat.run_end)
		else $error("sending from an empty slot or past the run limit");

	// Acknowledgements close every packet's results; payload items never do
	a_last_ack: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.last == result.kind))
		else $error("last flag does not match item kind");

endmodule

// File: hdl/srr_ram.sv
module srr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/srr_sequencer.sv
module srr_sequencer
	import srr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  srr_stat_t stat,
	output srr_ctrl_t ctrl
);

	step_t      step_q;
	step_t      step_d;
	ctrl_word_t uw;
	logic       go;
	logic       cond_hit;

	assign uw = ucode(step_q);

	// A step waits for an input transaction or a free output slot when it needs one
	assign go = (!uw.needs_in || stat.in_valid) && (!uw.needs_out || stat.out_free);

	// Condition select
	always_comb begin
		case (uw.cond)
			COND_DROP:     cond_hit = stat.drop;
			COND_BAD_CSUM: cond_hit = stat.bad_csum;
			COND_OUTSIDE:  cond_hit = stat.outside;
			COND_NOT_EXP:  cond_hit = stat.not_exp;
			COND_RUN_END:  cond_hit = stat.run_end;
			default:       cond_hit = 1'b0;
		endcase
	end

	// Next step
	always_comb begin
		step_d = step_q;
		if (go) begin
			case (uw.br)
				BR_NEXT: step_d = step_t'(step_q + 4'd1);
				BR_JUMP: step_d = uw.target;
				BR_IF:   step_d = cond_hit ? uw.target : step_t'(step_q + 4'd1);
				default: step_d = STEP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	assign ctrl.step = step_q;
	assign ctrl.uw   = uw;
	assign ctrl.go   = go;

endmodule

// File: hdl/srr_datapath.sv
module srr_datapath
	import srr_pkg::*;
#(
	parameter int SEQ_SPACE    = 16,
	parameter int WINDOW       = 8,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  srr_ctrl_t  ctrl,
	output srr_stat_t  stat,
	srr_pkt_if.sink    packet,
	srr_res_if.source  result
);

	localparam int BW       = $clog2(SEQ_SPACE);
	localparam int SCAN_MAX = (WINDOW - 1 < SEQ_SPACE - 1) ? WINDOW - 1 : SEQ_SPACE - 1;
	localparam int CW       = (SCAN_MAX < 2) ? 1 : $clog2(SCAN_MAX + 1);
	localparam logic [8:0]    SPACE9    = 9'(SEQ_SPACE);
	localparam logic [8:0]    WIN9      = 9'(WINDOW);
	localparam logic [BW:0]   SPACE_W   = (BW + 1)'(SEQ_SPACE);
	localparam logic [BW-1:0] LAST_SLOT = BW'(SEQ_SPACE - 1);
	localparam logic [CW-1:0] SCAN_LIM  = CW'(SCAN_MAX);

	// Latched packet
	logic [7:0]              seq_q;
	logic                    ok_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// Receiver state
	logic [BW-1:0]        base_q;
	logic [SEQ_SPACE-1:0] held_q;
	logic [4:0]           last_acked_q;
	logic [BW-1:0]        slot_q;
	logic [CW-1:0]        cnt_q;

	// Output register
	logic              out_valid_q;
	logic              kind_q;
	logic [63:0]       data_q;
	logic [4:0]        ack_q;
	logic [1:0]        status_q;
	logic              last_q;

	logic [BW-1:0]           seq_idx;
	logic [BW:0]             diff;
	logic [BW:0]             offset;
	logic [PAYLOAD_BITS-1:0] ram_rdata;
	logic                    out_free;
	logic [63:0]             item_ext;
	logic [63:0]             held_ext;
	logic [BW-1:0]           slot_inc;
	logic [BW-1:0]           base_inc;
	logic                    do_store;

	assign packet.ready = ctrl.uw.needs_in;
	assign seq_idx      = seq_q[BW-1:0];
	assign out_free     = !out_valid_q || result.ready;
	assign do_store     = ctrl.go && ctrl.uw.store;

	// Window offset (seq - base) mod SEQ_SPACE
	always_comb begin
		diff   = {1'b0, seq_idx} - {1'b0, base_q};
		offset = (seq_idx < base_q) ? diff + SPACE_W : diff;
	end

	assign slot_inc = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign base_inc = (base_q == LAST_SLOT) ? '0 : base_q + 1'b1;

	// Status for the sequencer's jumps
	assign stat.in_valid = packet.valid;
	assign stat.out_free = out_free;
	assign stat.drop     = {1'b0, seq_q} >= SPACE9;
	assign stat.bad_csum = !ok_q;
	assign stat.outside  = 9'(offset) >= WIN9;
	assign stat.not_exp  = seq_idx != base_q;
	assign stat.run_end  = (cnt_q == SCAN_LIM) || !held_q[slot_q];

	// Held payload store, read at the scan slot
	srr_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(SEQ_SPACE)
	) u_held (
		.clk  (clk),
		.we   (do_store),
		.waddr(seq_idx),
		.wdata(pay_q),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	// Packet latch
	always_ff @(posedge clk) begin
		if (ctrl.go && ctrl.uw.ld_item) begin
			seq_q <= packet.seq_num;
			ok_q  <= packet.checksum_ok;
			pay_q <= packet.payload[PAYLOAD_BITS-1:0];
		end
	end

	// Scan pointer and run count
	always_ff @(posedge clk) begin
		if (ctrl.go && ctrl.uw.scan_init) begin
			slot_q <= base_inc;
			cnt_q  <= '0;
		end else if (ctrl.go && ctrl.uw.scan_adv) begin
			slot_q <= slot_inc;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	// Window base, held flags, last ack number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			held_q       <= '0;
			last_acked_q <= ACK_NONE;
		end else begin
			if (ctrl.go && ctrl.uw.set_base) begin
				base_q <= slot_q;
			end
			if (ctrl.go && ctrl.uw.scan_adv) begin
				held_q[slot_q] <= 1'b0;
			end
			if (do_store) begin
				held_q[seq_idx] <= 1'b1;
			end
			if (ctrl.go && ctrl.uw.upd_ack) begin
				last_acked_q <= seq_q[4:0];
			end
		end
	end

	always_comb begin
		item_ext = '0;
		held_ext = '0;
		item_ext[PAYLOAD_BITS-1:0] = pay_q;
		held_ext[PAYLOAD_BITS-1:0] = ram_rdata;
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.go && ctrl.uw.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			case (ctrl.uw.emit)
				EMIT_ITEM_PAY: begin
					kind_q <= KIND_DATA; data_q <= item_ext;
					ack_q <= '0; status_q <= ACK_OK; last_q <= 1'b0;
				end
				EMIT_HELD_PAY: begin
					kind_q <= KIND_DATA; data_q <= held_ext;
					ack_q <= '0; status_q <= ACK_OK; last_q <= 1'b0;
				end
				EMIT_ACK_OK: begin
					kind_q <= KIND_ACK; data_q <= '0;
					ack_q <= seq_q[4:0]; status_q <= ACK_OK; last_q <= 1'b1;
				end
				EMIT_ACK_CSUM: begin
					kind_q <= KIND_ACK; data_q <= '0;
					ack_q <= last_acked_q; status_q <= ACK_CSUM_ERR; last_q <= 1'b1;
				end
				EMIT_ACK_SEQ: begin
					kind_q <= KIND_ACK; data_q <= '0;
					ack_q <= seq_q[4:0]; status_q <= ACK_SEQ_ERR; last_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.kind       = kind_q;
	assign result.data_out   = data_q;
	assign result.ack_num    = $signed(ack_q);
	assign result.ack_status = status_q;
	assign result.last       = last_q;

endmodule
